/* rtl/hps_pkg.sv */
// ----------------------------------------------------------------------------
// hps_pkg
// Shared types, codes and constants of the phase/enable H-bridge sequencer.
// ----------------------------------------------------------------------------
package hps_pkg;

    // Field widths
    localparam int MODE_W   = 2;
    localparam int DUTY_W   = 16;
    localparam int HELD_W   = 15;
    localparam int TIME_W   = 32;
    localparam int PERIOD_W = 16;
    localparam int DELAY_W  = 16;
    localparam int STATUS_W = 2;

    // Duty scaling: percent times DUTY_SCALE (DUTY_SCALE must be a power of two)
    localparam int DUTY_SCALE = 256;
    localparam int DUTY_SHIFT = $clog2(DUTY_SCALE);
    localparam int DUTY_PCT   = 100;
    localparam logic [DUTY_W-1:0] DUTY_MAX = DUTY_W'(DUTY_PCT * DUTY_SCALE);
    localparam int ROUND_HALF = (DUTY_PCT * DUTY_SCALE) / 2;

    // Dead time before a direction reversal, in milliseconds
    localparam logic [TIME_W-1:0] DEADTIME_MS = TIME_W'(1);

    // Reset values of the configuration registers
    localparam logic [PERIOD_W-1:0] PERIOD_RESET     = PERIOD_W'(1000);
    localparam logic [DELAY_W-1:0]  WAKE_DELAY_RESET = DELAY_W'(1);

    // Compare scaling: product, shifted product and reciprocal of DUTY_PCT
    localparam int PROD_W      = PERIOD_W + HELD_W;
    localparam int SHR_W       = PROD_W - DUTY_SHIFT;
    localparam int RECIP_SHIFT = 30;
    localparam int RECIP_W     = 24;
    localparam logic [RECIP_W-1:0] RECIP_MULT =
        RECIP_W'(((64'd1 << RECIP_SHIFT) + 64'(DUTY_PCT - 1)) / 64'(DUTY_PCT));
    localparam int QPROD_W     = SHR_W + RECIP_W;

    // Command kinds
    localparam logic [MODE_W-1:0] MODE_RUN   = 2'd0;
    localparam logic [MODE_W-1:0] MODE_BRAKE = 2'd1;
    localparam logic [MODE_W-1:0] MODE_SLEEP = 2'd2;

    // Status codes
    localparam logic [STATUS_W-1:0] ST_OK      = 2'd0;
    localparam logic [STATUS_W-1:0] ST_BUSY    = 2'd1;
    localparam logic [STATUS_W-1:0] ST_INVALID = 2'd2;

    // Configuration register indexes
    localparam int CFG_IDX_W = 1;
    localparam logic [CFG_IDX_W-1:0] REG_PWM_PERIOD = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_WAKE_DELAY = 1'd1;

    // One command as taken from the input channel
    typedef struct packed {
        logic [MODE_W-1:0] mode;
        logic              direction;
        logic [DUTY_W-1:0] duty_request;
        logic [TIME_W-1:0] time_ms;
    } cmd_t;

    // Sequencing result handed to the compare scaler
    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic                duty_wr;
        logic                phase_out;
        logic                wake_pin;
        logic [HELD_W-1:0]   duty_applied;
    } seq_res_t;

endpackage

/* rtl/hps_cmd_seq.sv */
// ----------------------------------------------------------------------------
// hps_cmd_seq
// Command sequencing stage: one command per cycle unless the output stalls;
// updates the bridge state, registers the resulting status and pin levels.
// ----------------------------------------------------------------------------
module hps_cmd_seq
    import hps_pkg::*;
(
    input  logic               aclk,
    input  logic               aresetn,
    input  logic [DELAY_W-1:0] wake_delay,
    input  logic               in_valid,
    output logic               in_ready,
    input  cmd_t               in_cmd,
    output logic               out_valid,
    input  logic               out_ready,
    output seq_res_t           out_res
);

    logic              awake_reg, awake_next;
    logic              dir_known_reg, dir_known_next;
    logic              phase_reg, phase_next;
    logic              pend_phase_reg, pend_phase_next;
    logic              rev_pend_reg, rev_pend_next;
    logic [TIME_W-1:0] wake_start_reg, wake_start_next;
    logic [TIME_W-1:0] rev_start_reg, rev_start_next;
    logic [HELD_W-1:0] duty_held_reg, duty_held_next;
    logic              valid_reg;
    seq_res_t          res_reg, res_next;

    logic              take;
    logic              duty_zero;
    logic              duty_over;
    logic              early_busy;
    logic [STATUS_W-1:0] status;
    logic              duty_wr;
    logic [HELD_W-1:0] duty_val;
    logic [TIME_W-1:0] wake_elapsed;
    logic [TIME_W-1:0] rev_elapsed;

    assign in_ready  = !valid_reg || out_ready;
    assign take      = in_valid && in_ready;
    assign out_valid = valid_reg;
    assign out_res   = res_reg;

    assign duty_zero    = (in_cmd.duty_request == '0);
    assign duty_over    = (in_cmd.duty_request > DUTY_MAX);
    assign wake_elapsed = in_cmd.time_ms - wake_start_reg;
    assign rev_elapsed  = in_cmd.time_ms - rev_start_reg;

    // Next bridge state for the command at the input
    always_comb begin
        awake_next      = awake_reg;
        dir_known_next  = dir_known_reg;
        phase_next      = phase_reg;
        pend_phase_next = pend_phase_reg;
        rev_pend_next   = rev_pend_reg;
        wake_start_next = wake_start_reg;
        rev_start_next  = rev_start_reg;
        status          = ST_OK;
        duty_wr         = 1'b1;
        duty_val        = '0;
        early_busy      = 1'b0;

        case (in_cmd.mode)
            MODE_RUN: begin
                if (duty_over) begin
                    status  = ST_INVALID;
                    duty_wr = 1'b0;
                end else if (duty_zero) begin
                    // zero duty behaves as brake
                    rev_pend_next = 1'b0;
                    if (!awake_reg) begin
                        awake_next      = 1'b1;
                        wake_start_next = in_cmd.time_ms;
                    end
                end else begin
                    if (!dir_known_reg || (phase_reg != in_cmd.direction)) begin
                        if (!awake_reg) begin
                            // asleep: switch phase at once
                            phase_next     = in_cmd.direction;
                            dir_known_next = 1'b1;
                            rev_pend_next  = 1'b0;
                        end else if (!rev_pend_reg
                                     || (pend_phase_reg != in_cmd.direction)) begin
                            // start dead time before the reversal
                            pend_phase_next = in_cmd.direction;
                            rev_start_next  = in_cmd.time_ms;
                            rev_pend_next   = 1'b1;
                            status          = ST_BUSY;
                            early_busy      = 1'b1;
                        end else if (rev_elapsed < DEADTIME_MS) begin
                            status     = ST_BUSY;
                            early_busy = 1'b1;
                        end else begin
                            phase_next     = pend_phase_reg;
                            dir_known_next = 1'b1;
                            rev_pend_next  = 1'b0;
                        end
                    end else begin
                        rev_pend_next = 1'b0;
                    end

                    if (!early_busy) begin
                        if (!awake_reg) begin
                            awake_next      = 1'b1;
                            wake_start_next = in_cmd.time_ms;
                            status          = ST_BUSY;
                        end else if (wake_elapsed < TIME_W'(wake_delay)) begin
                            status = ST_BUSY;
                        end else begin
                            duty_val = in_cmd.duty_request[HELD_W-1:0];
                        end
                    end
                end
            end
            MODE_BRAKE: begin
                rev_pend_next = 1'b0;
                if (!awake_reg) begin
                    awake_next      = 1'b1;
                    wake_start_next = in_cmd.time_ms;
                end
            end
            MODE_SLEEP: begin
                awake_next      = 1'b0;
                wake_start_next = '0;
                rev_pend_next   = 1'b0;
            end
            default: begin
                status  = ST_INVALID;
                duty_wr = 1'b0;
            end
        endcase

        duty_held_next = duty_wr ? duty_val : duty_held_reg;

        res_next.status       = status;
        res_next.duty_wr      = duty_wr;
        res_next.phase_out    = phase_next;
        res_next.wake_pin     = awake_next;
        res_next.duty_applied = duty_held_next;
    end

    // Advance state on each transfer
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            awake_reg      <= 1'b0;
            dir_known_reg  <= 1'b0;
            phase_reg      <= 1'b0;
            pend_phase_reg <= 1'b0;
            rev_pend_reg   <= 1'b0;
            wake_start_reg <= '0;
            rev_start_reg  <= '0;
            duty_held_reg  <= '0;
        end else if (take) begin
            awake_reg      <= awake_next;
            dir_known_reg  <= dir_known_next;
            phase_reg      <= phase_next;
            pend_phase_reg <= pend_phase_next;
            rev_pend_reg   <= rev_pend_next;
            wake_start_reg <= wake_start_next;
            rev_start_reg  <= rev_start_next;
            duty_held_reg  <= duty_held_next;
        end
    end

    // Result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (in_ready) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (take) begin
            res_reg <= res_next;
        end
    end

endmodule

/* rtl/hps_cmp_scale.sv */
// ----------------------------------------------------------------------------
// hps_cmp_scale
// Two-stage compare scaler: period times duty with rounding, then division
// by the percent scale through a reciprocal multiply; holds the compare
// register and the output register of the result channel.
// ----------------------------------------------------------------------------
module hps_cmp_scale
    import hps_pkg::*;
(
    input  logic                aclk,
    input  logic                aresetn,
    input  logic [PERIOD_W-1:0] pwm_period,
    input  logic                in_valid,
    output logic                in_ready,
    input  seq_res_t            in_res,
    output logic                out_valid,
    input  logic                out_ready,
    output seq_res_t            out_res,
    output logic [PERIOD_W-1:0] out_compare
);

    logic                valid1_reg;
    seq_res_t            res1_reg;
    logic [SHR_W-1:0]    shr1_reg;
    logic                ready1;

    logic                valid2_reg;
    seq_res_t            res2_reg;
    logic [PERIOD_W-1:0] cmp_reg, cmp_next;

    logic [PROD_W-1:0]   prod;
    logic [QPROD_W-1:0]  qprod;
    logic [PERIOD_W-1:0] active;

    assign ready1   = !valid2_reg || out_ready;
    assign in_ready = !valid1_reg || ready1;

    // Rounded product, then drop the power-of-two part of the scale
    assign prod = PROD_W'(pwm_period) * PROD_W'(in_res.duty_applied)
                  + PROD_W'(ROUND_HALF);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid1_reg <= 1'b0;
        end else if (in_ready) begin
            valid1_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_valid && in_ready) begin
            res1_reg <= in_res;
            shr1_reg <= prod[PROD_W-1:DUTY_SHIFT];
        end
    end

    // Divide by the percent factor; exact over the full shifted range
    assign qprod  = QPROD_W'(shr1_reg) * QPROD_W'(RECIP_MULT);
    assign active = qprod[RECIP_SHIFT +: PERIOD_W];

    // Hold the compare value on a rejected command
    assign cmp_next = res1_reg.duty_wr ? (pwm_period - active) : cmp_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid2_reg <= 1'b0;
            cmp_reg    <= PERIOD_RESET;
        end else begin
            if (ready1) begin
                valid2_reg <= valid1_reg;
            end
            if (valid1_reg && ready1) begin
                cmp_reg <= cmp_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (valid1_reg && ready1) begin
            res2_reg <= res1_reg;
        end
    end

    assign out_valid   = valid2_reg;
    assign out_res     = res2_reg;
    assign out_compare = cmp_reg;

endmodule

/* rtl/hbridge_phase_enable_sequencer.sv */
// ----------------------------------------------------------------------------
// hbridge_phase_enable_sequencer
// Phase/enable H-bridge command sequencer with wake delay, reversal dead
// time and PWM compare scaling.
// ----------------------------------------------------------------------------
// Takes one command (run, brake, sleep) per cycle while the result side does
// not stall, and returns one result per command, in order. The input register
// takes the command at the accepting edge; the result then passes the
// sequencing stage, the multiply stage, and the reciprocal stage that loads
// the output register. The bridge state loop (awake, phase, pending reversal,
// timestamps) closes within the sequencing stage, so back-to-back commands
// see each other's effect with no gap. The compare value is pwm_period -
// round(pwm_period * duty / 25600) and holds on a rejected command. The user
// must write configuration only while idle; the block does not enforce this.
module hbridge_phase_enable_sequencer
    import hps_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 cfg_wr_en,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [PERIOD_W-1:0]  cfg_wr_data,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  logic [MODE_W-1:0]    s_mode,
    input  logic                 s_direction,
    input  logic [DUTY_W-1:0]    s_duty_request,
    input  logic [TIME_W-1:0]    s_time_ms,
    output logic                 m_valid,
    input  logic                 m_ready,
    output logic [STATUS_W-1:0]  m_status,
    output logic [PERIOD_W-1:0]  m_compare_value,
    output logic                 m_phase_out,
    output logic                 m_wake_pin,
    output logic [HELD_W-1:0]    m_duty_applied
);

    logic [PERIOD_W-1:0] pwm_period_reg;
    logic [DELAY_W-1:0]  wake_delay_reg;

    logic     in_valid_reg;
    cmd_t     in_cmd_reg;
    logic     seq_in_ready;
    logic     seq_valid;
    logic     scl_ready;
    seq_res_t seq_res;
    seq_res_t out_res;

    // Configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pwm_period_reg <= PERIOD_RESET;
            wake_delay_reg <= WAKE_DELAY_RESET;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                REG_PWM_PERIOD: pwm_period_reg <= cfg_wr_data;
                REG_WAKE_DELAY: wake_delay_reg <= DELAY_W'(cfg_wr_data);
                default: ;
            endcase
        end
    end

    // Input register
    assign s_ready = !in_valid_reg || seq_in_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_ready) begin
            in_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_cmd_reg.mode         <= s_mode;
            in_cmd_reg.direction    <= s_direction;
            in_cmd_reg.duty_request <= s_duty_request;
            in_cmd_reg.time_ms      <= s_time_ms;
        end
    end

    hps_cmd_seq u_cmd_seq (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .wake_delay (wake_delay_reg),
        .in_valid   (in_valid_reg),
        .in_ready   (seq_in_ready),
        .in_cmd     (in_cmd_reg),
        .out_valid  (seq_valid),
        .out_ready  (scl_ready),
        .out_res    (seq_res)
    );

    hps_cmp_scale u_cmp_scale (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .pwm_period  (pwm_period_reg),
        .in_valid    (seq_valid),
        .in_ready    (scl_ready),
        .in_res      (seq_res),
        .out_valid   (m_valid),
        .out_ready   (m_ready),
        .out_res     (out_res),
        .out_compare (m_compare_value)
    );

    assign m_status       = out_res.status;
    assign m_phase_out    = out_res.phase_out;
    assign m_wake_pin     = out_res.wake_pin;
    assign m_duty_applied = out_res.duty_applied;

`ifndef SYNTH
    // Nonzero duty only while awake
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_duty_applied == '0) || m_wake_pin)
        else $error("duty applied while bridge asleep");

    // A busy answer always holds zero duty
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && (m_status == ST_BUSY)) |-> (m_duty_applied == '0))
        else $error("busy status with nonzero duty");

    // Applied duty never exceeds full scale
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (HELD_W'(DUTY_MAX) >= m_duty_applied))
        else $error("applied duty above full scale");
`endif

endmodule
